// ===== rtl/dbe_pkg.sv =====
// ============================================================================
// dbe_pkg: shared types and constants of the dark boost exposure block
// Pixel payloads, pipeline records and the fixed-point constants.
// ============================================================================
package dbe_pkg;

    localparam int CHAN_W     = 8;
    localparam int FRAC_W     = 16;
    localparam int PWR_W      = FRAC_W + 1;
    localparam int BOOST_W    = 20;
    localparam int CURVE_W    = 4;
    localparam int STRENGTH_W = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    typedef logic [CURVE_W:0] curve_lim_t;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_BOOST_STRENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_POWER    = 1'd1;

    localparam logic [STRENGTH_W-1:0] STRENGTH_RESET = 4'd2;
    localparam logic [CURVE_W-1:0]    CURVE_RESET    = 4'd2;

    localparam logic [PWR_W-1:0]   ONE_Q16    = 17'h10000;
    localparam logic [BOOST_W-1:0] BOOST_MAX  = 20'hFFFFF;
    localparam logic [15:0]        ROUND_HALF = 16'h8000;
    localparam logic [CHAN_W-1:0]  CHAN_MAX   = 8'hFF;

    // floor(x / 3) equals (x * 683) >> 11 for every x below 2048.
    localparam logic [9:0] DIV3_RECIP = 10'd683;
    localparam int         DIV3_SHIFT = 11;

    typedef struct packed {
        logic [CHAN_W-1:0] blue_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] red_in;
    } pixel_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blue_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] red_out;
    } pixel_out_t;

    typedef struct packed {
        logic [FRAC_W-1:0] dark;
        logic [PWR_W-1:0]  pwr;
        pixel_in_t         pix;
    } pwr_t;

    typedef struct packed {
        logic [BOOST_W-1:0] boost;
        pixel_in_t          pix;
    } bst_t;

endpackage

// ===== rtl/dbe_pixel_if.sv =====
// ============================================================================
// dbe_pixel_if: pixel stream interfaces
// Valid/ready channels for the input pixel and the boosted result pixel.
// ============================================================================
interface dbe_pixel_in_if;
    import dbe_pkg::*;

    logic      valid;
    logic      ready;
    pixel_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dbe_pixel_out_if;
    import dbe_pkg::*;

    logic       valid;
    logic       ready;
    pixel_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/dbe_power_stage.sv =====
// ============================================================================
// dbe_power_stage: one step of the darkness power chain
// Multiplies the running power by the darkness when this step is in use,
// otherwise passes it on; one registered stage with its own handshake.
// ============================================================================
module dbe_power_stage #(
    parameter int STAGE_IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dbe_pkg::curve_lim_t curve_lim,
    input  logic              up_valid,
    input  dbe_pkg::pwr_t     up_data,
    output logic              up_ready,
    output logic              dn_valid,
    output dbe_pkg::pwr_t     dn_data,
    input  logic              dn_ready
);
    import dbe_pkg::*;

    logic                      valid_reg;
    pwr_t                      data_reg;
    pwr_t                      data_next;
    logic [PWR_W+FRAC_W-1:0]   prod;

    always_comb
    begin
        prod      = (PWR_W + FRAC_W)'(up_data.pwr) * (PWR_W + FRAC_W)'(up_data.dark);
        data_next = up_data;
        if (curve_lim_t'(STAGE_IDX) < curve_lim)
        begin
            data_next.pwr = prod[PWR_W+FRAC_W-1:FRAC_W];
        end
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/dbe_lane.sv =====
// ============================================================================
// dbe_lane: channel scaling lane
// Scales one color channel by the boost with round-to-nearest and clamps
// the result to the channel range.
// ============================================================================
module dbe_lane (
    input  logic [dbe_pkg::CHAN_W-1:0]  chan,
    input  logic [dbe_pkg::BOOST_W-1:0] boost,
    output logic [dbe_pkg::CHAN_W-1:0]  chan_out
);
    import dbe_pkg::*;

    localparam int PROD_W = CHAN_W + BOOST_W + 1;

    logic [PROD_W-1:0]        prod;
    logic [PROD_W-FRAC_W-1:0] scaled;

    always_comb
    begin
        prod   = PROD_W'(chan) * PROD_W'(boost) + PROD_W'(ROUND_HALF);
        scaled = prod[PROD_W-1:FRAC_W];
        if (scaled > (PROD_W - FRAC_W)'(CHAN_MAX))
        begin
            chan_out = CHAN_MAX;
        end
        else
        begin
            chan_out = scaled[CHAN_W-1:0];
        end
    end

endmodule

// ===== rtl/dbe_lane_merge.sv =====
// ============================================================================
// dbe_lane_merge: three channel lanes and the result register
// Runs one scaling lane per color channel and gathers the lanes into the
// registered result pixel.
// ============================================================================
module dbe_lane_merge (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    input  dbe_pkg::bst_t      up_data,
    output logic               up_ready,
    output logic               dn_valid,
    output dbe_pkg::pixel_out_t dn_data,
    input  logic               dn_ready
);
    import dbe_pkg::*;

    logic       valid_reg;
    pixel_out_t data_reg;
    pixel_out_t data_next;

    dbe_lane u_lane_blue (
        .chan     (up_data.pix.blue_in),
        .boost    (up_data.boost),
        .chan_out (data_next.blue_out)
    );

    dbe_lane u_lane_green (
        .chan     (up_data.pix.green_in),
        .boost    (up_data.boost),
        .chan_out (data_next.green_out)
    );

    dbe_lane u_lane_red (
        .chan     (up_data.pix.red_in),
        .boost    (up_data.boost),
        .chan_out (data_next.red_out)
    );

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

`ifndef SYNTH
    // A boost of at least one never darkens a channel.
    a_lane_not_darker: assert property (@(posedge clk) disable iff (!rst_n)
        up_valid |-> (data_next.blue_out >= up_data.pix.blue_in)
                  && (data_next.green_out >= up_data.pix.green_in)
                  && (data_next.red_out >= up_data.pix.red_in))
        else $error("lane result darker than its input");

    // A result only appears after a boosted pixel was waiting.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_reg) |-> $past(up_valid))
        else $error("result appeared without a boosted pixel");

    // A boost of exactly one leaves the blue channel unchanged.
    a_unity_boost: assert property (@(posedge clk) disable iff (!rst_n)
        (up_valid && up_ready && (up_data.boost == BOOST_W'(ONE_Q16)))
        |=> (data_reg.blue_out == $past(up_data.pix.blue_in)))
        else $error("unity boost changed the pixel");
`endif

endmodule

// ===== rtl/dark_boost_exposure.sv =====
// ============================================================================
// dark_boost_exposure: darkness-weighted exposure boost
// The block accepts one BGR pixel per clock cycle and returns one boosted
// pixel per cycle while the result side is ready, through an intensity
// stage, a chain of MAX_CURVE registered 17x16 multiply stages that raise
// the darkness to the curve power, a boost stage, and the three channel
// lanes feeding the result register. Every stage keeps its own valid bit, so
// empty stages fill while a finished result waits to be taken. Write the
// two configuration registers only while no transaction is in flight.
// ============================================================================
module dark_boost_exposure #(
    parameter int MAX_CURVE = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dbe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dbe_pkg::CFG_DATA_W-1:0]   cfg_data,
    dbe_pixel_in_if.sink                     pixel,
    dbe_pixel_out_if.source                  result
);
    import dbe_pkg::*;

    logic [STRENGTH_W-1:0] strength_reg;
    logic [STRENGTH_W-1:0] strength_next;
    logic [CURVE_W-1:0]    curve_reg;
    logic [CURVE_W-1:0]    curve_next;
    curve_lim_t            curve_lim;

    logic                  s0_valid_reg;
    pwr_t                  s0_reg;
    pwr_t                  s0_next;
    logic [9:0]            chan_sum;
    logic [19:0]           div_prod;
    logic [CHAN_W-1:0]     intensity;

    logic                  pw_valid [MAX_CURVE+1];
    pwr_t                  pw_data  [MAX_CURVE+1];
    logic                  pw_ready [MAX_CURVE+1];

    logic                  bst_valid_reg;
    bst_t                  bst_reg;
    bst_t                  bst_next;
    logic                  bst_ready;
    logic [BOOST_W+1:0]    boost_wide;

    // Configuration registers.
    always_comb
    begin
        strength_next = strength_reg;
        curve_next    = curve_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_BOOST_STRENGTH: strength_next = cfg_data[STRENGTH_W-1:0];
                REG_CURVE_POWER:    curve_next    = cfg_data[CURVE_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_reg <= STRENGTH_RESET;
            curve_reg    <= CURVE_RESET;
        end
        else
        begin
            strength_reg <= strength_next;
            curve_reg    <= curve_next;
        end
    end

    assign curve_lim = (curve_lim_t'(curve_reg) > curve_lim_t'(MAX_CURVE))
                     ? curve_lim_t'(MAX_CURVE) : curve_lim_t'(curve_reg);

    // Intensity stage. Darkness (255 - i) * 257 is the inverted byte repeated.
    always_comb
    begin
        chan_sum  = 10'(pixel.data.blue_in) + 10'(pixel.data.green_in)
                  + 10'(pixel.data.red_in);
        div_prod  = 20'(chan_sum) * 20'(DIV3_RECIP);
        intensity = div_prod[DIV3_SHIFT+CHAN_W-1:DIV3_SHIFT];
        s0_next.dark = {~intensity, ~intensity};
        s0_next.pwr  = ONE_Q16;
        s0_next.pix  = pixel.data;
    end

    assign pixel.ready = !s0_valid_reg || pw_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (pixel.ready)
        begin
            s0_valid_reg <= pixel.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel.ready && pixel.valid)
        begin
            s0_reg <= s0_next;
        end
    end

    // Power chain.
    assign pw_valid[0] = s0_valid_reg;
    assign pw_data[0]  = s0_reg;

    for (genvar k = 0; k < MAX_CURVE; k++)
    begin : g_power
        dbe_power_stage #(
            .STAGE_IDX (k)
        ) u_power_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .curve_lim (curve_lim),
            .up_valid  (pw_valid[k]),
            .up_data   (pw_data[k]),
            .up_ready  (pw_ready[k]),
            .dn_valid  (pw_valid[k+1]),
            .dn_data   (pw_data[k+1]),
            .dn_ready  (pw_ready[k+1])
        );
    end

    assign pw_ready[MAX_CURVE] = !bst_valid_reg || bst_ready;

    // Boost stage: 1.0 + strength * d^curve, saturated to 4.16.
    always_comb
    begin
        boost_wide = (BOOST_W + 2)'(ONE_Q16)
                   + (BOOST_W + 2)'(strength_reg) * (BOOST_W + 2)'(pw_data[MAX_CURVE].pwr);
        bst_next.pix = pw_data[MAX_CURVE].pix;
        if (boost_wide > (BOOST_W + 2)'(BOOST_MAX))
        begin
            bst_next.boost = BOOST_MAX;
        end
        else
        begin
            bst_next.boost = boost_wide[BOOST_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bst_valid_reg <= 1'b0;
        end
        else if (pw_ready[MAX_CURVE])
        begin
            bst_valid_reg <= pw_valid[MAX_CURVE];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pw_ready[MAX_CURVE] && pw_valid[MAX_CURVE])
        begin
            bst_reg <= bst_next;
        end
    end

    // Channel lanes and result register.
    dbe_lane_merge u_lane_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (bst_valid_reg),
        .up_data  (bst_reg),
        .up_ready (bst_ready),
        .dn_valid (result.valid),
        .dn_data  (result.data),
        .dn_ready (result.ready)
    );

`ifndef SYNTH
    // The powered darkness never exceeds one.
    a_power_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pw_valid[MAX_CURVE] |-> (pw_data[MAX_CURVE].pwr <= ONE_Q16))
        else $error("powered darkness above one");

    // The boost is never below one.
    a_boost_floor: assert property (@(posedge clk) disable iff (!rst_n)
        bst_valid_reg |-> (bst_reg.boost >= BOOST_W'(ONE_Q16)))
        else $error("boost below one");

    // A boost stage fill needs a pixel at the end of the power chain.
    a_boost_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(bst_valid_reg) |-> $past(pw_valid[MAX_CURVE]))
        else $error("boost stage filled without a pixel");

    // The darkness of a stored pixel is its inverted intensity byte repeated.
    a_dark_shape: assert property (@(posedge clk) disable iff (!rst_n)
        s0_valid_reg |-> (s0_reg.dark[15:8] == s0_reg.dark[7:0]))
        else $error("malformed darkness value");
`endif

endmodule

// ===== bench/tb_dark_boost_exposure.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_dark_boost_exposure: self-checking bench for the dark boost exposure block
// A table of directed pixels and settings is walked first, then random pixels
// under a series of boost and curve settings. Every result transaction is
// compared per channel against a typed result or the in-bench boost model.
// ============================================================================
module tb_dark_boost_exposure;
    import dbe_pkg::*;

    localparam int MAX_CURVE    = 10;
    localparam int LATENCY      = MAX_CURVE + 3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 10;
    localparam int PHASE_PIXELS = 130;
    localparam int HOLD_CYCLES  = 80;
    localparam int HOLD_AFTER   = 330;
    localparam bit TYPED        = 1'b1;
    localparam bit PREDICT      = 1'b0;

    // One directed transaction: the settings it runs under, the pixel, and
    // optionally a result written out by hand.
    typedef struct packed {
        logic [STRENGTH_W-1:0] strength;
        logic [CURVE_W-1:0]    curve;
        pixel_in_t             px;
        logic                  typed;
        pixel_out_t            want;
    } stimulus_row_t;

    localparam int DIRECTED_ROWS = 21;
    localparam stimulus_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        // Reset settings: black stays black, white stays white.
        '{4'd2, 4'd2, '{8'd0, 8'd0, 8'd0}, TYPED, '{8'd0, 8'd0, 8'd0}},
        '{4'd2, 4'd2, '{8'd255, 8'd255, 8'd255}, TYPED, '{8'd255, 8'd255, 8'd255}},
        '{4'd2, 4'd2, '{8'd255, 8'd0, 8'd0}, PREDICT, '0},
        '{4'd2, 4'd2, '{8'd0, 8'd0, 8'd255}, PREDICT, '0},
        '{4'd2, 4'd2, '{8'd40, 8'd30, 8'd20}, PREDICT, '0},
        // Zero strength passes the pixel through.
        '{4'd0, 4'd5, '{8'd17, 8'd128, 8'd255}, TYPED, '{8'd17, 8'd128, 8'd255}},
        '{4'd0, 4'd5, '{8'd0, 8'd0, 8'd0}, TYPED, '{8'd0, 8'd0, 8'd0}},
        // Strength 15 with a flat curve overflows the boost and saturates it.
        '{4'd15, 4'd0, '{8'd255, 8'd255, 8'd255}, TYPED, '{8'd255, 8'd255, 8'd255}},
        '{4'd15, 4'd0, '{8'd0, 8'd0, 8'd0}, TYPED, '{8'd0, 8'd0, 8'd0}},
        '{4'd15, 4'd0, '{8'd1, 8'd2, 8'd3}, PREDICT, '0},
        '{4'd10, 4'd10, '{8'd0, 8'd0, 8'd0}, TYPED, '{8'd0, 8'd0, 8'd0}},
        '{4'd10, 4'd10, '{8'd10, 8'd12, 8'd14}, PREDICT, '0},
        '{4'd10, 4'd10, '{8'd128, 8'd128, 8'd128}, PREDICT, '0},
        // Curve above the limit is clamped.
        '{4'd15, 4'd15, '{8'd5, 8'd0, 8'd0}, PREDICT, '0},
        '{4'd15, 4'd15, '{8'd0, 8'd255, 8'd0}, PREDICT, '0},
        '{4'd15, 4'd15, '{8'd255, 8'd255, 8'd255}, TYPED, '{8'd255, 8'd255, 8'd255}},
        '{4'd7, 4'd11, '{8'd20, 8'd20, 8'd20}, PREDICT, '0},
        '{4'd7, 4'd11, '{8'd254, 8'd255, 8'd255}, PREDICT, '0},
        '{4'd0, 4'd0, '{8'd200, 8'd100, 8'd50}, TYPED, '{8'd200, 8'd100, 8'd50}},
        '{4'd1, 4'd1, '{8'd99, 8'd3, 8'd250}, PREDICT, '0},
        '{4'd1, 4'd1, '{8'd127, 8'd128, 8'd129}, PREDICT, '0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dbe_pixel_in_if  pix_if ();
    dbe_pixel_out_if res_if ();

    dark_boost_exposure #(
        .MAX_CURVE (MAX_CURVE)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pix_if),
        .result    (res_if)
    );

    pixel_out_t            expected_pixels [$];
    logic [STRENGTH_W-1:0] strength_setting;
    logic [CURVE_W-1:0]    curve_setting;
    int                    pixels_sent;
    int                    pixels_checked;
    int                    settings_used;
    int                    fail_count;
    int                    cycle_count;
    bit                    quiet_tail;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [CHAN_W-1:0] scaled_channel(logic [CHAN_W-1:0] chan,
                                                          logic [BOOST_W-1:0] boost);
        logic [28:0] product;
        product = 29'(chan) * 29'(boost) + 29'(ROUND_HALF);
        return (product[28:16] > 13'(CHAN_MAX)) ? CHAN_MAX : product[23:16];
    endfunction

    // Brightened pixel for the given settings: darkness raised to the
    // clamped curve power, scaled by strength, then applied to each channel.
    function automatic pixel_out_t boosted_pixel(pixel_in_t px,
                                                 logic [STRENGTH_W-1:0] strength,
                                                 logic [CURVE_W-1:0] curve);
        logic [9:0]         chan_sum;
        logic [7:0]         intensity;
        logic [FRAC_W-1:0]  darkness;
        logic [PWR_W-1:0]   powered;
        logic [32:0]        product;
        logic [23:0]        boost_wide;
        logic [BOOST_W-1:0] boost;
        int                 steps;
        pixel_out_t         res;
        chan_sum   = 10'(px.blue_in) + 10'(px.green_in) + 10'(px.red_in);
        intensity  = 8'(chan_sum / 10'd3);
        darkness   = (16'd255 - 16'(intensity)) * 16'd257;
        steps      = (int'(curve) > MAX_CURVE) ? MAX_CURVE : int'(curve);
        powered    = ONE_Q16;
        for (int i = 0; i < steps; i++)
        begin
            product = 33'(powered) * 33'(darkness);
            powered = product[32:16];
        end
        boost_wide = 24'(ONE_Q16) + 24'(strength) * 24'(powered);
        boost      = (boost_wide > 24'(BOOST_MAX)) ? BOOST_MAX : boost_wide[BOOST_W-1:0];
        res.blue_out  = scaled_channel(px.blue_in, boost);
        res.green_out = scaled_channel(px.green_in, boost);
        res.red_out   = scaled_channel(px.red_in, boost);
        return res;
    endfunction

    task automatic send_pixel(pixel_in_t px);
        pix_if.valid <= 1'b1;
        pix_if.data  <= px;
        do
            @(posedge clk);
        while (!pix_if.ready);
        pixels_sent++;
    endtask

    task automatic maybe_pause(bit enabled);
        if (enabled && $urandom_range(0, 3) == 0)
        begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    // Settings change only with the pipeline empty.
    task automatic apply_settings(logic [STRENGTH_W-1:0] strength,
                                  logic [CURVE_W-1:0] curve);
        pix_if.valid <= 1'b0;
        @(posedge clk);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= REG_BOOST_STRENGTH;
        cfg_data  <= strength;
        @(posedge clk);
        cfg_index <= REG_CURVE_POWER;
        cfg_data  <= curve;
        @(posedge clk);
        cfg_we    <= 1'b0;
        strength_setting = strength;
        curve_setting    = curve;
        settings_used++;
    endtask

    // Result side: random stalls, one long hold-off, and a clean tail.
    initial
    begin
        bit held;
        held = 1'b0;
        res_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!quiet_tail && !held && pixels_checked >= HOLD_AFTER)
            begin
                held = 1'b1;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet_tail && $urandom_range(0, 4) == 0)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        pixel_out_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("result transaction with nothing expected: %p", res_if.data);
                fail_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (res_if.data.blue_out !== want.blue_out)
                begin
                    $error("blue_out expected %0d actual %0d",
                           want.blue_out, res_if.data.blue_out);
                    fail_count++;
                end
                if (res_if.data.green_out !== want.green_out)
                begin
                    $error("green_out expected %0d actual %0d",
                           want.green_out, res_if.data.green_out);
                    fail_count++;
                end
                if (res_if.data.red_out !== want.red_out)
                begin
                    $error("red_out expected %0d actual %0d",
                           want.red_out, res_if.data.red_out);
                    fail_count++;
                end
                pixels_checked++;
            end
        end
    end

    initial
    begin
        stimulus_row_t         row;
        pixel_in_t             px;
        logic [STRENGTH_W-1:0] strength;
        logic [CURVE_W-1:0]    curve;
        bit                    gaps;
        pixels_sent      = 0;
        pixels_checked   = 0;
        settings_used    = 1;
        fail_count       = 0;
        quiet_tail       = 1'b0;
        strength_setting = STRENGTH_RESET;
        curve_setting    = CURVE_RESET;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_BOOST_STRENGTH;
        cfg_data     <= '0;
        pix_if.valid <= 1'b0;
        pix_if.data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = DIRECTED[i];
            if (row.strength != strength_setting || row.curve != curve_setting)
                apply_settings(row.strength, row.curve);
            send_pixel(row.px);
            expected_pixels.push_back(row.typed ? row.want
                                      : boosted_pixel(row.px, strength_setting,
                                                      curve_setting));
            maybe_pause(1'b1);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: begin strength = 4'd10; curve = 4'd10; end
                1: begin strength = 4'd15; curve = 4'd15; end
                2: begin strength = 4'd0;  curve = 4'd10; end
                3: begin strength = 4'd10; curve = 4'd0;  end
                default:
                begin
                    strength = STRENGTH_W'($urandom_range(0, 15));
                    curve    = CURVE_W'($urandom_range(0, 15));
                end
            endcase
            apply_settings(strength, curve);
            quiet_tail = (phase == PHASES - 1);
            gaps = !quiet_tail && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < PHASE_PIXELS; n++)
            begin
                // Mostly uniform pixels, with dark, grey and bright ones mixed in.
                case ($urandom_range(0, 9))
                    6, 7: px = '{8'($urandom_range(0, 48)), 8'($urandom_range(0, 48)),
                                 8'($urandom_range(0, 48))};
                    8:
                    begin
                        px.blue_in  = 8'($urandom_range(0, 255));
                        px.green_in = px.blue_in;
                        px.red_in   = px.blue_in;
                    end
                    9: px = '{8'($urandom_range(200, 255)), 8'($urandom_range(200, 255)),
                              8'($urandom_range(200, 255))};
                    default: px = 24'($urandom);
                endcase
                send_pixel(px);
                expected_pixels.push_back(boosted_pixel(px, strength_setting,
                                                        curve_setting));
                maybe_pause(gaps);
            end
        end

        pix_if.valid <= 1'b0;
        wait_drained();
        repeat (2 * LATENCY) @(posedge clk);

        $display("Sent %0d pixels, checked %0d boosted results.",
                 pixels_sent, pixels_checked);
        $display("Covered %0d strength/curve settings, saturation and clamp cases.",
                 settings_used);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
